// ===== hdl/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types and constants for the rotated one-bit-per-pixel frame buffer.
// ----------------------------------------------------------------------------
package rpf_pkg;

  // Default panel geometry
  localparam int DEF_PANEL_WIDTH  = 104;
  localparam int DEF_PANEL_HEIGHT = 212;

  // Fixed field widths
  localparam int CW  = 10;   // coordinate width
  localparam int BIW = 12;   // byte_index width
  localparam int AWP = 3;    // APB address width

  // Byte constants
  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] MASK_MSB   = 8'h80;

  // Register index decoded from paddr[2]
  localparam logic REG_ROTATION = 1'b0;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_DRAW = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Memory address source
  typedef enum logic [1:0] {
    ASEL_SWEEP = 2'd0,
    ASEL_PIXEL = 2'd1,
    ASEL_BYTE  = 2'd2
  } addr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;      // latch input transaction
    logic      map_en;       // register rotated coordinates
    logic      addr_en;      // register byte address and bit mask
    logic      mem_rd;       // read memory at selected address
    logic      pix_wr;       // write back modified byte
    logic      sweep_wr;     // write fill byte at sweep counter
    logic      sweep_white;  // force white fill (reset clear)
    logic      emit;         // present result next cycle
    addr_sel_t addr_sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
  } sts_t;

endpackage

// ===== hdl/rpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpf_ctrl
// Sequencer for fill sweeps, pixel read-modify-write and byte reads.
// ----------------------------------------------------------------------------
module rpf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    kind,
  input  rpf_pkg::sts_t sts,
  output rpf_pkg::cmd_t cmd,
  output logic          busy
);
  import rpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MAP,
    S_ADDR,
    S_RMW_RD,
    S_RMW_WR,
    S_RD,
    S_EMIT
  } state_t;

  state_t state;
  logic   boot;   // sweep after reset emits no result

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      boot  <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              KIND_FILL: state <= S_SWEEP;
              KIND_DRAW: state <= S_MAP;
              KIND_READ: state <= S_RD;
              default:   state <= S_EMIT;
            endcase
          end
        end
        S_SWEEP: begin
          if (sts.sweep_last) begin
            boot  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_MAP:    state <= S_ADDR;
        S_ADDR:   state <= S_RMW_RD;
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: state <= S_IDLE;
        S_RD:     state <= S_EMIT;
        S_EMIT:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd             = '0;
    cmd.addr_sel    = ASEL_SWEEP;
    cmd.capture     = (state == S_IDLE) && start;
    cmd.sweep_white = boot;
    case (state)
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        cmd.emit     = sts.sweep_last && !boot;
      end
      S_MAP:  cmd.map_en  = 1'b1;
      S_ADDR: cmd.addr_en = 1'b1;
      S_RMW_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ASEL_PIXEL;
      end
      S_RMW_WR: begin
        cmd.pix_wr   = 1'b1;
        cmd.addr_sel = ASEL_PIXEL;
        cmd.emit     = 1'b1;
      end
      S_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ASEL_BYTE;
      end
      S_EMIT:  cmd.emit = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/rpf_datapath.sv =====
// ----------------------------------------------------------------------------
// rpf_datapath
// Frame store memory, coordinate rotation, address generation and results.
// ----------------------------------------------------------------------------
module rpf_datapath #(
  parameter int PANEL_WIDTH  = rpf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rpf_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rpf_pkg::cmd_t           cmd,
  output rpf_pkg::sts_t           sts,
  input  logic [1:0]              rotation,
  input  logic [1:0]              kind,
  input  logic [rpf_pkg::CW-1:0]  pos_x,
  input  logic [rpf_pkg::CW-1:0]  pos_y,
  input  logic                    ink,
  input  logic [rpf_pkg::BIW-1:0] byte_index,
  output logic                    done,
  output logic [7:0]              read_data,
  output logic                    accepted
);
  import rpf_pkg::*;

  localparam int ROW_BYTES   = PANEL_WIDTH / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IW = $clog2(STORE_BYTES + ROW_BYTES + 1);

  // Captured transaction
  logic [1:0]     kind_q;
  logic [CW-1:0]  x_q;
  logic [CW-1:0]  y_q;
  logic           ink_q;
  logic [BIW-1:0] bidx_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      x_q    <= pos_x;
      y_q    <= pos_y;
      ink_q  <= ink;
      bidx_q <= byte_index;
    end
  end

  // Bounds check against rotated extents and quarter-turn mapping
  logic [CW:0]   lw;
  logic [CW:0]   lh;
  logic          inb;
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic [CW-1:0] px_q;
  logic [CW-1:0] py_q;
  logic          inb_q;

  always_comb begin
    lw  = rotation[0] ? (CW+1)'(PANEL_HEIGHT) : (CW+1)'(PANEL_WIDTH);
    lh  = rotation[0] ? (CW+1)'(PANEL_WIDTH)  : (CW+1)'(PANEL_HEIGHT);
    inb = !x_q[CW-1] && !y_q[CW-1] && ({1'b0, x_q} < lw) && ({1'b0, y_q} < lh);
    case (rotation)
      2'd1: begin
        px = CW'(PANEL_WIDTH - 1) - y_q;
        py = x_q;
      end
      2'd2: begin
        px = CW'(PANEL_WIDTH - 1) - x_q;
        py = CW'(PANEL_HEIGHT - 1) - y_q;
      end
      2'd3: begin
        px = y_q;
        py = CW'(PANEL_HEIGHT - 1) - x_q;
      end
      default: begin
        px = x_q;
        py = y_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      px_q  <= px;
      py_q  <= py;
      inb_q <= inb;
    end
  end

  // Byte address and bit mask
  logic [IW-1:0] idx;
  logic [AW-1:0] idx_q;
  logic [7:0]    mask_q;
  logic          pix_ok_q;

  assign idx = IW'(py_q) * IW'(ROW_BYTES) + IW'(px_q[CW-1:3]);

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      idx_q    <= AW'(idx);
      mask_q   <= MASK_MSB >> px_q[2:0];
      pix_ok_q <= inb_q && (idx < IW'(STORE_BYTES));
    end
  end

  // Read index range check
  logic rd_ok;
  assign rd_ok = ({20'd0, bidx_q} < 32'(STORE_BYTES));

  // Sweep counter, wraps to zero after the last byte
  logic [AW-1:0] cnt;
  assign sts.sweep_last = (cnt == AW'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep_wr) begin
      cnt <= sts.sweep_last ? '0 : cnt + 1'b1;
    end
  end

  // Memory address and write data selection
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic          we;
  logic          re;
  logic [7:0]    mem_q;

  always_comb begin
    case (cmd.addr_sel)
      ASEL_PIXEL: addr = idx_q;
      ASEL_BYTE:  addr = AW'(bidx_q);
      default:    addr = cnt;
    endcase
    if (cmd.sweep_wr) begin
      wdata = (cmd.sweep_white || ink_q) ? BYTE_WHITE : BYTE_BLACK;
    end else begin
      wdata = ink_q ? (mem_q | mask_q) : (mem_q & ~mask_q);
    end
    we = cmd.sweep_wr || (cmd.pix_wr && pix_ok_q);
    re = cmd.mem_rd && ((cmd.addr_sel == ASEL_PIXEL) ? pix_ok_q : rd_ok);
  end

  // Frame store
  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[addr];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (kind_q)
        KIND_FILL: begin
          read_data <= BYTE_BLACK;
          accepted  <= 1'b1;
        end
        KIND_DRAW: begin
          read_data <= BYTE_BLACK;
          accepted  <= pix_ok_q;
        end
        KIND_READ: begin
          read_data <= rd_ok ? mem_q : BYTE_BLACK;
          accepted  <= rd_ok;
        end
        default: begin
          read_data <= BYTE_BLACK;
          accepted  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rotated_pixel_framebuffer.sv =====
// ----------------------------------------------------------------------------
// rotated_pixel_framebuffer
// One-bit-per-pixel frame store with fill, rotated pixel draw and byte read.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Signals
//  --------  ---------------------  -------------------------------------------
//  command   start & !busy          kind, pos_x, pos_y, ink, byte_index
//  result    done (one cycle)       read_data, accepted
//  config    APB psel/penable/pwrite paddr, pwdata, prdata, pready
//
//  Busy states per transaction: fill writes every byte of the store (one byte
//  written per cycle on the single memory port), draw steps through map, address,
//  read and write back, read through read and emit, unused kind through emit only.
//  done is registered and rises in the cycle after the last busy cycle. After reset
//  the store is cleared to white while busy is high; configuration writes are taken meanwhile.
//  The result is a strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rotated_pixel_framebuffer #(
  parameter int PANEL_WIDTH  = rpf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rpf_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic signed [rpf_pkg::CW-1:0] pos_x,
  input  logic signed [rpf_pkg::CW-1:0] pos_y,
  input  logic                    ink,
  input  logic [rpf_pkg::BIW-1:0] byte_index,
  // result channel
  output logic                    done,
  output logic [7:0]              read_data,
  output logic                    accepted,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [rpf_pkg::AWP-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rpf_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] rotation;

  // Rotation register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROTATION)) begin
      rotation <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROTATION) ? {30'd0, rotation} : 32'd0;

  // Controller
  rpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath
  rpf_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .rotation   (rotation),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .ink        (ink),
    .byte_index (byte_index),
    .done       (done),
    .read_data  (read_data),
    .accepted   (accepted)
  );

endmodule

// ===== tb/sv/tb_rotated_pixel_framebuffer.sv =====
// ----------------------------------------------------------------------------
// tb_rotated_pixel_framebuffer
// Self-checking bench for the rotated one-bit-per-pixel frame buffer. Fill,
// draw, read and unused-kind commands go in on the start/busy handshake,
// directed corner cases first and then random traffic under each rotation
// setting. A scoreboard keeps its own copy of the frame store and rotation,
// predicts every result strobe and compares it field by field.
// ----------------------------------------------------------------------------
module tb_rotated_pixel_framebuffer;
  timeunit 1ns;
  timeprecision 1ps;

  import rpf_pkg::*;

  localparam int PANEL_W     = DEF_PANEL_WIDTH;
  localparam int PANEL_H     = DEF_PANEL_HEIGHT;
  localparam int ROW_BYTES   = PANEL_W / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;

  // Register map and rotation settings
  localparam logic [AWP-1:0] ADDR_ROTATION = 3'd0;
  localparam logic [AWP-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam int ITEMS_PER_PHASE = 75;

  // --------------------------------------------------------------------------
  // Scoreboard: frame store shadow, rotation shadow, expected result queue
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    logic [7:0] store [STORE_BYTES];
    logic [1:0] rot;
    logic [7:0] exp_data [$];
    logic       exp_acc  [$];
    int last_idx;
    int errors;
    int checked;
    int n_fill, n_draw_in, n_draw_out, n_read_ok, n_read_out, n_none;

    function new();
      foreach (store[i]) store[i] = BYTE_WHITE;
      rot = ROT_0;
      last_idx = 0;
      errors = 0;
      checked = 0;
      n_fill = 0; n_draw_in = 0; n_draw_out = 0;
      n_read_ok = 0; n_read_out = 0; n_none = 0;
    endfunction

    function void set_rotation(logic [1:0] r);
      rot = r;
    endfunction

    // Bounds check, quarter-turn map, then set or clear one bit
    function bit paint_pixel(int x, int y, logic i);
      int lw, lh, px, py, idx;
      logic [7:0] mask;
      lw = rot[0] ? PANEL_H : PANEL_W;
      lh = rot[0] ? PANEL_W : PANEL_H;
      if (x < 0 || x >= lw || y < 0 || y >= lh) return 1'b0;
      case (rot)
        ROT_90: begin
          px = PANEL_W - 1 - y;
          py = x;
        end
        ROT_180: begin
          px = PANEL_W - 1 - x;
          py = PANEL_H - 1 - y;
        end
        ROT_270: begin
          px = y;
          py = PANEL_H - 1 - x;
        end
        default: begin
          px = x;
          py = y;
        end
      endcase
      idx = py * ROW_BYTES + px / 8;
      if (idx >= STORE_BYTES) return 1'b0;
      mask = MASK_MSB >> (px & 7);
      if (i) store[idx] = store[idx] | mask;
      else   store[idx] = store[idx] & ~mask;
      last_idx = idx;
      return 1'b1;
    endfunction

    // Accepted command transaction: update shadow state, queue the result
    function void note_command(kind_t k, logic signed [CW-1:0] x,
                               logic signed [CW-1:0] y, logic i,
                               logic [BIW-1:0] b);
      int xi, yi;
      logic [7:0] d;
      logic a;
      xi = x;
      yi = y;
      d = 8'h00;
      a = 1'b0;
      case (k)
        KIND_FILL: begin
          foreach (store[n]) store[n] = i ? BYTE_WHITE : BYTE_BLACK;
          a = 1'b1;
          n_fill++;
        end
        KIND_DRAW: begin
          a = paint_pixel(xi, yi, i);
          if (a) n_draw_in++;
          else   n_draw_out++;
        end
        KIND_READ: begin
          if (b < STORE_BYTES) begin
            d = store[b];
            a = 1'b1;
            n_read_ok++;
          end else begin
            n_read_out++;
          end
        end
        default: n_none++;
      endcase
      exp_data.push_back(d);
      exp_acc.push_back(a);
    endfunction

    // Result strobe: compare against the oldest expectation
    function void check_result(logic [7:0] d, logic a);
      logic [7:0] ed;
      logic ea;
      if (exp_data.size() == 0) begin
        $display("%0t: unexpected result read_data=%02h accepted=%0b", $time, d, a);
        errors++;
        return;
      end
      ed = exp_data.pop_front();
      ea = exp_acc.pop_front();
      checked++;
      if (d !== ed) begin
        $display("%0t: read_data mismatch expected %02h actual %02h", $time, ed, d);
        errors++;
      end
      if (a !== ea) begin
        $display("%0t: accepted mismatch expected %0b actual %0b", $time, ea, a);
        errors++;
      end
    endfunction

    function int pending();
      return exp_data.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            kind = KIND_NONE;
  logic signed [CW-1:0]  pos_x = '0;
  logic signed [CW-1:0]  pos_y = '0;
  logic                  ink = 1'b0;
  logic [BIW-1:0]        byte_index = '0;
  logic                  done;
  logic [7:0]            read_data;
  logic                  accepted;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AWP-1:0]        paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  pixel_scoreboard sb = new();
  bit no_gaps = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  rotated_pixel_framebuffer dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .ink        (ink),
    .byte_index (byte_index),
    .done       (done),
    .read_data  (read_data),
    .accepted   (accepted),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Result monitor; the strobe cannot be stalled
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(read_data, accepted);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Mostly short idles, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // start stays high from one transaction to the next unless a gap is taken
  task automatic send_cmd(input kind_t k, input logic signed [CW-1:0] x,
                          input logic signed [CW-1:0] y, input logic i,
                          input logic [BIW-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    pos_x      <= x;
    pos_y      <= y;
    ink        <= i;
    byte_index <= b;
    do @(posedge clk); while (busy);
    sb.note_command(k, x, y, i, b);
  endtask

  // Drop start and wait until every result is back and the block is idle
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic apb_write(input logic [AWP-1:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ADDR_ROTATION) sb.set_rotation(v[1:0]);
    // Leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  // Read the rotation register back and compare
  task automatic check_rotation_reg();
    logic [31:0] exp_val;
    exp_val = {30'd0, sb.rot};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ROTATION;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_val) begin
      $display("%0t: rotation register mismatch expected %08h actual %08h",
               $time, exp_val, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // In-range coordinate mostly, sometimes an edge value, sometimes anything
  function automatic int pick_coord(int lim);
    int r;
    logic signed [CW-1:0] v;
    r = $urandom_range(0, 99);
    v = CW'($urandom);
    if (r < 70) return $urandom_range(0, lim - 1);
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return lim - 1;
        2: return lim;
        default: return -1;
      endcase
    end
    return v;
  endfunction

  // Random command; draws dominate, reads often hit the last drawn byte
  task automatic random_item();
    int sel, r, lw, lh;
    kind_t k;
    logic signed [CW-1:0] x, y;
    logic [BIW-1:0] b;
    sel = $urandom_range(0, 99);
    x = CW'($urandom);
    y = CW'($urandom);
    b = BIW'($urandom);
    lw = sb.rot[0] ? PANEL_H : PANEL_W;
    lh = sb.rot[0] ? PANEL_W : PANEL_H;
    if (sel < 2) begin
      k = KIND_FILL;
    end else if (sel < 5) begin
      k = KIND_NONE;
    end else if (sel < 60) begin
      k = KIND_DRAW;
      x = CW'(pick_coord(lw));
      y = CW'(pick_coord(lh));
    end else begin
      k = KIND_READ;
      r = $urandom_range(0, 99);
      if (r < 50)      b = BIW'(sb.last_idx);
      else if (r < 85) b = BIW'($urandom_range(0, STORE_BYTES - 1));
    end
    send_cmd(k, x, y, 1'($urandom), b);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] rot_seq [7];
    rot_seq = '{ROT_270, ROT_90, ROT_180, ROT_0, ROT_90, ROT_270, ROT_180};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Wait out the clear-to-white pass that follows reset
    @(posedge clk);
    while (busy) @(posedge clk);
    check_rotation_reg();

    // Directed: store ends, read range, bounds on every side, unused kind, fills
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, BIW'(STORE_BYTES - 1));
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, BIW'(STORE_BYTES));
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b1, 12'hFFF);
    send_cmd(KIND_DRAW, 10'sd0, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_DRAW, CW'(PANEL_W - 1), CW'(PANEL_H - 1), 1'b0, 12'hFFF);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, BIW'(STORE_BYTES - 1));
    send_cmd(KIND_DRAW, -10'sd1, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_DRAW, 10'sd0, -10'sd512, 1'b0, 12'd0);
    send_cmd(KIND_DRAW, CW'(PANEL_W), 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_DRAW, 10'sd0, CW'(PANEL_H), 1'b0, 12'd0);
    send_cmd(KIND_DRAW, 10'sd511, 10'sd511, 1'b1, 12'd0);
    send_cmd(KIND_DRAW, -10'sd512, -10'sd1, 1'b0, 12'd0);
    send_cmd(KIND_NONE, -10'sd1, -10'sd1, 1'b1, 12'hFFF);
    send_cmd(KIND_DRAW, 10'sd0, 10'sd0, 1'b1, 12'd0);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_FILL, 10'sd0, 10'sd0, 1'b0, 12'd0);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, 12'd1377);
    send_cmd(KIND_DRAW, 10'sd7, 10'sd5, 1'b1, 12'd0);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, BIW'(5 * ROW_BYTES));
    send_cmd(KIND_FILL, -10'sd1, -10'sd1, 1'b1, 12'hFFF);
    send_cmd(KIND_READ, 10'sd0, 10'sd0, 1'b0, BIW'(5 * ROW_BYTES));

    // Random phases, one rotation setting each, some without idles
    foreach (rot_seq[p]) begin
      quiesce();
      apb_write(ADDR_ROTATION, ($urandom() & ~32'h3) | {30'd0, rot_seq[p]});
      if (p == 3) apb_write(ADDR_UNMAPPED, $urandom());
      check_rotation_reg();
      no_gaps = (p % 3 == 1);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    quiesce();
    repeat (10) @(posedge clk);
    $display("Covered %0d results: %0d fills, %0d draws in bounds, %0d rejected draws",
             sb.checked, sb.n_fill, sb.n_draw_in, sb.n_draw_out);
    $display("  %0d reads in range, %0d past the end, %0d unused-kind commands",
             sb.n_read_ok, sb.n_read_out, sb.n_none);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
